[rtl/top_key_frequency_table_assert.svh]
// Assertion macros shared by the key frequency table checker.
// No dependencies; include once per file that asserts.
`ifndef TOP_KEY_FREQUENCY_TABLE_ASSERT_SVH
`define TOP_KEY_FREQUENCY_TABLE_ASSERT_SVH

// next-cycle implication, quiet while reset is high
`define TKFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define TKFT_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tkft_pkg.sv]
// Types and constants for the key frequency table.
// No dependencies.
package tkft_pkg;

  localparam int TABLE_SIZE_DEF = 16;
  localparam int MAX_OUT        = 16;
  localparam int KEY_W          = 32;
  localparam int CNT_W          = 32;
  localparam int LIM_W          = 5;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] blocked;
    logic             used;
    logic             done;   // already emitted in this readout
  } slot_t;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_CLEAR,
    OP_MARK,
    OP_HIT,
    OP_NEW
  } head_op_t;

  typedef struct packed {
    head_op_t         op;
    logic [KEY_W-1:0] key;
    logic             blk;
  } head_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_APPLY,
    ST_SCAN,
    ST_EMIT
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

[rtl/top_key_frequency_table.sv]
// Key frequency table: ring of TABLE_SIZE slot cells rotating past one head unit.
// Record: after accept, a find pass, then an update pass, over the ring; the next item
// is taken once both passes are done. Readout: a scan pass, then an emit step, per emitted entry, plus output stalls.
// Rate is set by the ring rotation: one slot passes the head unit per cycle while the ring shifts (find, apply, scan).
// Reset (rst, synchronous, active high) clears every slot and the output valid.
module top_key_frequency_table #(
  parameter int TABLE_SIZE = tkft_pkg::TABLE_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // [31:0] item_key, [36:32] readout_limit, rest zero
  input  logic [1:0]   s_tuser,   // [0] command, [1] was_blocked
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // [31:0] entry_key, [63:32] entry_total,
                                  // [95:64] entry_blocked
  output logic         m_tuser,   // [0] entry_used
  output logic         m_tlast    // last_entry
);
  import tkft_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CAP   = (TABLE_SIZE < MAX_OUT) ? TABLE_SIZE : MAX_OUT;
  localparam logic [LIM_W-1:0] CAP_V   = LIM_W'(CAP);
  localparam logic [IDX_W-1:0] POS_END = IDX_W'(TABLE_SIZE - 1);

  // ring: slot at ring[0] is at the head; pos is its slot index
  slot_t     ring [TABLE_SIZE];
  slot_t     head_out;
  head_ctl_t ctl;
  logic      shift;

  state_t state, state_next;
  logic [IDX_W-1:0] pos;
  logic             pass_end;

  // request
  logic [KEY_W-1:0] req_key;
  logic             req_blk;

  // record search results
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] vic_idx;
  logic [CNT_W-1:0] vic_min;
  logic [IDX_W-1:0] tgt_idx;

  // readout selection
  logic             first_pass;
  logic             mark_pending;
  logic [IDX_W-1:0] mark_idx;
  logic             best_valid;
  slot_t            best;
  logic [IDX_W-1:0] best_idx;
  logic [LIM_W-1:0] n_out;
  logic [LIM_W-1:0] cnt;
  logic [LIM_W-1:0] cnt_inc;
  logic             eligible;
  logic             out_free;
  logic             emit_last;

  logic             in_acc;
  logic [LIM_W-1:0] lim_in;
  logic [LIM_W-1:0] n_in;

  assign in_acc    = s_tvalid && s_tready;
  assign lim_in    = s_tdata[36:32];
  assign n_in      = (lim_in > CAP_V) ? CAP_V : lim_in;
  assign pass_end  = (pos == POS_END);
  assign tgt_idx   = hit ? hit_idx : vic_idx;
  assign out_free  = !m_tvalid || m_tready;
  assign cnt_inc   = cnt + LIM_W'(1);
  assign emit_last = (cnt_inc == n_out);

  // ring of cells, tail fed from the head unit
  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    slot_t d;
    if (i == TABLE_SIZE - 1) begin : g_tail
      assign d = head_out;
    end else begin : g_mid
      assign d = ring[i+1];
    end
    tkft_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .d    (d),
      .q    (ring[i])
    );
  end

  tkft_head u_head (
    .cur(ring[0]),
    .ctl(ctl),
    .nxt(head_out)
  );

  // slot at head counts as a readout candidate unless already emitted
  assign eligible = first_pass ||
                    !(ring[0].done || (mark_pending && pos == mark_idx));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (!s_tuser[0]) begin
            state_next = ST_FIND;
          end else if (n_in != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_FIND:  if (pass_end) state_next = ST_APPLY;
      ST_APPLY: if (pass_end) state_next = ST_IDLE;
      ST_SCAN:  if (pass_end) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = emit_last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    shift    = 1'b0;
    ctl.op   = OP_PASS;
    ctl.key  = req_key;
    ctl.blk  = req_blk;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_FIND: shift = 1'b1;
      ST_APPLY: begin
        shift = 1'b1;
        if (pos == tgt_idx) begin
          ctl.op = hit ? OP_HIT : OP_NEW;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (first_pass) begin
          ctl.op = OP_CLEAR;
        end else if (mark_pending && pos == mark_idx) begin
          ctl.op = OP_MARK;
        end
      end
      ST_EMIT: shift = 1'b0;
      default: shift = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath (no reset needed: set up at accept)
  always_ff @(posedge clk) begin
    if (shift) begin
      pos <= pass_end ? '0 : pos + IDX_W'(1);
    end
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          pos          <= '0;
          req_key      <= s_tdata[31:0];
          req_blk      <= s_tuser[1];
          hit          <= 1'b0;
          first_pass   <= 1'b1;
          mark_pending <= 1'b0;
          best_valid   <= 1'b0;
          n_out        <= n_in;
          cnt          <= '0;
        end
      end
      ST_FIND: begin
        if (!hit && ring[0].used && ring[0].key == req_key) begin
          hit     <= 1'b1;
          hit_idx <= pos;
        end
        // strict compare keeps the first slot holding the minimum
        if (pos == '0 || ring[0].total < vic_min) begin
          vic_min <= ring[0].total;
          vic_idx <= pos;
        end
      end
      ST_SCAN: begin
        // strict compare keeps ties in slot order
        if (eligible && (!best_valid || ring[0].total > best.total)) begin
          best_valid <= 1'b1;
          best       <= ring[0];
          best_idx   <= pos;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_tdata      <= {best.blocked, best.total, best.key};
          m_tuser      <= best.used;
          m_tlast      <= emit_last;
          mark_idx     <= best_idx;
          mark_pending <= 1'b1;
          first_pass   <= 1'b0;
          best_valid   <= 1'b0;
          cnt          <= cnt_inc;
        end
      end
      default: begin
        first_pass <= first_pass;
      end
    endcase
  end

endmodule

[rtl/tkft_cell.sv]
// One slot of the rotating table ring.
// Depends on tkft_pkg.
module tkft_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  tkft_pkg::slot_t d,
  output tkft_pkg::slot_t q
);
  import tkft_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

[rtl/tkft_head.sv]
// Update unit at the head of the ring: rewrites the slot passing by.
// Depends on tkft_pkg.
module tkft_head (
  input  tkft_pkg::slot_t     cur,
  input  tkft_pkg::head_ctl_t ctl,
  output tkft_pkg::slot_t     nxt
);
  import tkft_pkg::*;

  always_comb begin
    nxt = cur;
    case (ctl.op)
      OP_PASS:  nxt = cur;
      OP_CLEAR: nxt.done = 1'b0;
      OP_MARK:  nxt.done = 1'b1;
      OP_HIT: begin
        nxt.total = sat_inc(cur.total);
        if (ctl.blk) begin
          nxt.blocked = sat_inc(cur.blocked);
        end
      end
      OP_NEW: begin
        nxt.key     = ctl.key;
        nxt.used    = 1'b1;
        nxt.total   = {{(CNT_W-1){1'b0}}, 1'b1};
        nxt.blocked = {{(CNT_W-1){1'b0}}, ctl.blk};
      end
      default: nxt = cur;
    endcase
  end

endmodule

[rtl/tkft_checker.sv]
// Port-level checker for the key frequency table, bound to the top level.
// Depends on top_key_frequency_table_assert.svh.
`include "top_key_frequency_table_assert.svh"

module tkft_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  `TKFT_ASSERT_NEXT_RST(a_rst_clears_out, rst, !m_tvalid, "output valid after reset")
  `TKFT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")
  `TKFT_ASSERT_NEXT(a_record_busy, s_tvalid && s_tready && !s_tuser[0], !s_tready, "ready right after record")
  `TKFT_ASSERT_NEXT(a_record_silent, s_tvalid && s_tready && !s_tuser[0], !$rose(m_tvalid), "record made a result")

endmodule

bind top_key_frequency_table tkft_checker u_tkft_checker (.*);
